// ===== rtl/btmx_pkg.sv =====
// Shared types and codes for the binary trie maximum-XOR block.
package btmx_pkg;

    // Width of the key and result fields on the ports.
    localparam int KEY_W = 40;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [KEY_W-1:0] value;
        logic             found;
        logic             pool_full;
    } res_t;

endpackage

// ===== rtl/btmx_node_mem.sv =====
// Node store: synchronous memory of child index pairs, registered read.
module btmx_node_mem
    import btmx_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int IW    = 12
)
(
    input  logic            clk,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_addr,
    output logic [2*IW-1:0] rd_data,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  logic [2*IW-1:0] wr_data
);

    logic [2*IW-1:0] mem [DEPTH];
    logic [2*IW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/btmx_ctrl.sv =====
// Command sequencer: walks the trie one level a cycle and allocates nodes.
module btmx_ctrl
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = 40,
    parameter int NODE_COUNT = 4096,
    parameter int IW         = 12
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      cmd,
    input  logic [KEY_W-1:0] key,
    input  logic            slot_free,
    output logic            done,
    output res_t            res,
    output logic            rd_en,
    output logic [IW-1:0]   rd_addr,
    input  logic [2*IW-1:0] rd_data,
    output logic            wr_en,
    output logic [IW-1:0]   wr_addr,
    output logic [2*IW-1:0] wr_data
);

    localparam int LW = $clog2(KEY_BITS + 1);
    localparam int UW = IW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_ALLOC,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KEY_BITS:0] sh_reg, sh_next;
    logic [LW-1:0]     level_reg, level_next;
    logic [IW-1:0]     node_reg, node_next;
    logic [KEY_BITS-1:0] acc_reg, acc_next;
    logic [IW-1:0]     root0_reg, root0_next;
    logic [IW-1:0]     root1_reg, root1_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [IW-1:0]     par0_reg, par0_next;
    logic [IW-1:0]     par1_reg, par1_next;
    logic              pbit_reg, pbit_next;
    res_t              res_reg, res_next;

    logic [IW-1:0]       cur0, cur1, cb, ob, walk_next;
    logic                kb, last, opp_hit;
    logic [KEY_BITS-1:0] acc_step;
    logic [LW-1:0]       missing;
    logic [UW:0]         need;
    logic [IW-1:0]       new_idx, nxt_idx;
    logic [KEY_BITS-1:0] key_k;

    assign key_k    = KEY_BITS'(key);
    assign cur0     = (level_reg == '0) ? root0_reg : rd_data[IW-1:0];
    assign cur1     = (level_reg == '0) ? root1_reg : rd_data[2*IW-1:IW];
    assign kb       = sh_reg[KEY_BITS];
    assign cb       = kb ? cur1 : cur0;
    assign ob       = kb ? cur0 : cur1;
    assign last     = (level_reg == LW'(KEY_BITS - 1));
    assign opp_hit  = (ob != '0);
    assign walk_next = opp_hit ? ob : cb;
    assign acc_step = (acc_reg << 1) | KEY_BITS'(opp_hit);
    assign missing  = LW'(KEY_BITS) - level_reg;
    assign need     = {1'b0, used_reg} + (UW + 1)'(missing);
    assign new_idx  = used_reg[IW-1:0];
    assign nxt_idx  = new_idx + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        sh_next    = sh_reg;
        level_next = level_reg;
        node_next  = node_reg;
        acc_next   = acc_reg;
        root0_next = root0_reg;
        root1_next = root1_reg;
        used_next  = used_reg;
        par0_next  = par0_reg;
        par1_next  = par1_reg;
        pbit_next  = pbit_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = walk_next;
        wr_en      = 1'b0;
        wr_addr    = node_reg;
        wr_data    = '0;
        done       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd_t'(cmd);
                    sh_next    = {key_k, 1'b0};
                    level_next = '0;
                    node_next  = '0;
                    acc_next   = '0;
                    res_next   = '0;
                    state_next = (cmd_t'(cmd) == CMD_NONE) ? S_DONE : S_WALK;
                end
            end

            S_WALK:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (cb == '0)
                        begin
                            // hold the parent entry for the write-back
                            par0_next  = cur0;
                            par1_next  = cur1;
                            pbit_next  = kb;
                            state_next = S_CHECK;
                        end
                        else if (last)
                        begin
                            res_next.found = 1'b1;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cb;
                            node_next  = cb;
                            level_next = level_reg + LW'(1);
                            sh_next    = sh_reg << 1;
                        end
                    end

                    CMD_LOOKUP:
                    begin
                        if (cb == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (last)
                        begin
                            res_next.found = 1'b1;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cb;
                            node_next  = cb;
                            level_next = level_reg + LW'(1);
                            sh_next    = sh_reg << 1;
                        end
                    end

                    CMD_QUERY:
                    begin
                        if (level_reg == '0 && cur0 == '0 && cur1 == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else if (walk_next == '0 || last)
                        begin
                            res_next.value = KEY_W'(acc_step);
                            res_next.found = 1'b1;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = walk_next;
                            node_next  = walk_next;
                            acc_next   = acc_step;
                            level_next = level_reg + LW'(1);
                            sh_next    = sh_reg << 1;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CHECK:
            begin
                if (need > (UW + 1)'(NODE_COUNT))
                begin
                    // drop: not enough free nodes for the whole path
                    res_next.pool_full = 1'b1;
                    state_next         = S_DONE;
                end
                else
                begin
                    if (node_reg == '0)
                    begin
                        if (pbit_reg)
                        begin
                            root1_next = new_idx;
                        end
                        else
                        begin
                            root0_next = new_idx;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = node_reg;
                        wr_data = pbit_reg ? {new_idx, par0_reg} : {par1_reg, new_idx};
                    end
                    state_next = S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                wr_en   = 1'b1;
                wr_addr = new_idx;
                if (last)
                begin
                    wr_data        = '0;
                    res_next.found = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    wr_data = sh_reg[KEY_BITS-1] ? {nxt_idx, IW'(0)} : {IW'(0), nxt_idx};
                end
                used_next  = used_reg + UW'(1);
                level_next = level_reg + LW'(1);
                sh_next    = sh_reg << 1;
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root0_reg <= '0;
            root1_reg <= '0;
            used_reg  <= UW'(1);
        end
        else
        begin
            state_reg <= state_next;
            root0_reg <= root0_next;
            root1_reg <= root1_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        sh_reg    <= sh_next;
        level_reg <= level_next;
        node_reg  <= node_next;
        acc_reg   <= acc_next;
        par0_reg  <= par0_next;
        par1_reg  <= par1_next;
        pbit_reg  <= pbit_next;
        res_reg   <= res_next;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign res      = res_reg;

endmodule

// ===== rtl/binary_trie_max_xor.sv =====
// Top level of the binary trie maximum-XOR block.
//
// Usage: one input word carries a command (insert, maximum-XOR query or exact
// lookup) and a key; every input word yields exactly one output word.
// Both channels use valid/stall; a word moves on a rising edge with valid
// high and stall low.
// The trie walk advances one level per cycle, bounded by the single read
// port of the node memory; the root's two children sit in flip-flops.
// An insert that allocates a full path runs one walk step, a pool check with
// parent write-back, one node write per new level, then hand-over. One
// command is in work at a time; the next word is taken the cycle after a
// result enters the output register.
// The output register lets a result wait under stall while the next command
// is accepted and walked; the sequencer holds its result until the register
// is free.
// Reset empties the trie (root children cleared, pool count back to one)
// at once; no clearing pass runs over the node memory.
module binary_trie_max_xor
    import btmx_pkg::*;
#(
    parameter int KEY_BITS   = 40,
    parameter int NODE_COUNT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       cmd,
    input  logic [KEY_W-1:0] key,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [KEY_W-1:0] result_value,
    output logic             found,
    output logic             pool_full
);

    localparam int IW = $clog2(NODE_COUNT);

    logic            rd_en, wr_en, done, slot_free;
    logic [IW-1:0]   rd_addr, wr_addr;
    logic [2*IW-1:0] rd_data, wr_data;
    res_t            res;

    logic            out_valid_reg;
    res_t            out_res_reg;

    // the output register is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    btmx_ctrl #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT),
        .IW         (IW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .key       (key),
        .slot_free (slot_free),
        .done      (done),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    btmx_node_mem #(
        .DEPTH (NODE_COUNT),
        .IW    (IW)
    ) u_node_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // output word register: valid cleared under reset, payload loaded on hand-over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_res_reg.value;
    assign found        = out_res_reg.found;
    assign pool_full    = out_res_reg.pool_full;

endmodule
